// ===== rtl/swfp_pkg.sv =====
// Shared constants and control types for the scale weight frame parser.
// No dependencies; used by swfp_ctrl, swfp_datapath and the top level.
`default_nettype none

package swfp_pkg;

    // Frame geometry
    localparam int FRAME_LEN_DEF = 14;
    localparam int FRAME_LEN_MIN = 12;
    localparam int OFS_HEAD      = 0;
    localparam int OFS_WT_FIRST  = 2;
    localparam int OFS_UNIT_K    = 10;
    localparam int OFS_UNIT_G    = 11;
    localparam int PARSE_STEPS   = 8;
    localparam int STEP_W        = 3;
    localparam int CNT8_W        = 4;

    // Result field widths
    localparam int MANT_W = 27;
    localparam int EXP_W  = 4;

    // Exponent when the weight field has no point
    localparam logic [EXP_W-1:0] EXP_NO_POINT = 4'd7;

    // Result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_FRAME = 1'b1;

    // Character codes
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_K     = 8'h6B;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // Controller to datapath
    typedef struct packed {
        logic load;         // latch the item's end flag; shift the item into the window below the read limit
        logic start_parse;  // frame seen: copy weight bytes, mark found
        logic step_parse;   // handle one weight byte
        logic emit_ok;      // load a frame result into the output register
        logic emit_nf;      // load a no-frame result into the output register
        logic end_read;     // clear the per-read count and found flag
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hit;          // window holds the first frame of this read
        logic last;         // item under work ends the read
        logic found;        // a frame was already reported in this read
        logic parse_done;   // last weight byte is being handled
        logic out_free;     // output register can take a result now
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/scale_weight_frame_parser_top.sv =====
// Top level of the scale weight frame parser: controller plus datapath.
// Depends on swfp_pkg, swfp_ctrl and swfp_datapath.
`default_nettype none

// Scale weight frame parser. Feed the bytes of one serial read, one item per
// byte, with end_of_read set on the final byte. The block keeps a window of the
// last FRAME_LEN bytes; the first window of a read that starts with 'w' and has
// "kg" at offsets 10 and 11 yields one result: status 0, the digits of offsets
// 2..9 joined into mantissa, and exponent such that weight = mantissa * 10^exp
// (minus the digit count after the last point, or 7 minus the digit count when
// there is no point). Other bytes in that field are skipped. A read that ends
// without a frame yields status 1 with mantissa and exponent zero. Bytes past
// 2*FRAME_LEN in one read are ignored, except that their end_of_read still
// ends the read. Steps: an item that produces no result goes through accept
// and frame check; one that completes a frame then goes through the digit
// accumulator (one weight byte per cycle over 8 bytes) and the result load; a
// no-frame result follows the check. in_ready is high only between items.
// A finished result sits in the output register while the next byte is taken;
// the block loads no new result until that register has been drained.
module scale_weight_frame_parser_top #(
    parameter int FRAME_LEN = swfp_pkg::FRAME_LEN_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [7:0]                         rx_byte,
    input  wire logic                               end_of_read,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    status,
    output logic [swfp_pkg::MANT_W-1:0]             mantissa,
    output logic signed [swfp_pkg::EXP_W-1:0]       exponent
);

    swfp_pkg::cmd_t  cmd;
    swfp_pkg::stat_t st;

    swfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Offsets 0..11 must lie inside the window
    swfp_datapath #(
        .FRAME_LEN (FRAME_LEN)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .rx_byte     (rx_byte),
        .end_of_read (end_of_read),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .status      (status),
        .mantissa    (mantissa),
        .exponent    (exponent)
    );

endmodule

`default_nettype wire

// ===== rtl/swfp_datapath.sv =====
// Datapath: byte window, per-read counters, digit accumulator, output register.
// Depends on swfp_pkg; driven by swfp_ctrl.
`default_nettype none

module swfp_datapath #(
    parameter int FRAME_LEN = swfp_pkg::FRAME_LEN_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire swfp_pkg::cmd_t                     cmd,
    output swfp_pkg::stat_t                         st,
    input  wire logic [7:0]                         rx_byte,
    input  wire logic                               end_of_read,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic                                    status,
    output logic [swfp_pkg::MANT_W-1:0]             mantissa,
    output logic signed [swfp_pkg::EXP_W-1:0]       exponent
);

    localparam int READ_LIMIT = 2 * FRAME_LEN;
    localparam int CNT_W      = $clog2(READ_LIMIT + 1);
    localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(READ_LIMIT);
    localparam logic [CNT_W-1:0] FRAME_C = CNT_W'(FRAME_LEN);
    localparam int MW = swfp_pkg::MANT_W;
    localparam int EW = swfp_pkg::EXP_W;
    localparam int SW = swfp_pkg::STEP_W;
    localparam int CW = swfp_pkg::CNT8_W;

    logic [7:0]     win_reg   [FRAME_LEN];
    logic [7:0]     win_next  [FRAME_LEN];
    logic [7:0]     wt_reg    [swfp_pkg::PARSE_STEPS];
    logic [7:0]     wt_next   [swfp_pkg::PARSE_STEPS];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic           found_reg, found_next;
    logic           shifted_reg, shifted_next;
    logic           last_reg, last_next;
    logic [SW-1:0]  step_reg, step_next;
    logic [MW-1:0]  mant_reg, mant_next;
    logic [CW-1:0]  digits_reg, digits_next;
    logic [CW-1:0]  after_reg, after_next;
    logic           point_reg, point_next;
    logic           out_valid_reg, out_valid_next;
    logic           status_reg, status_next;
    logic [MW-1:0]  mantissa_reg, mantissa_next;
    logic [EW-1:0]  exponent_reg, exponent_next;

    logic [7:0]     cur_byte;
    logic           is_digit;
    logic [3:0]     digit_val;
    logic [EW-1:0]  exp_calc;

    assign cur_byte  = wt_reg[0];
    assign is_digit  = (cur_byte >= swfp_pkg::CH_0) && (cur_byte <= swfp_pkg::CH_9);
    assign digit_val = 4'(cur_byte - swfp_pkg::CH_0);
    assign exp_calc  = point_reg ? (EW'(0) - EW'(after_reg))
                                 : (swfp_pkg::EXP_NO_POINT - EW'(digits_reg));

    always_comb
    begin
        st.hit        = shifted_reg && !found_reg && (cnt_reg >= FRAME_C)
                        && (win_reg[swfp_pkg::OFS_HEAD]   == swfp_pkg::CH_W)
                        && (win_reg[swfp_pkg::OFS_UNIT_K] == swfp_pkg::CH_K)
                        && (win_reg[swfp_pkg::OFS_UNIT_G] == swfp_pkg::CH_G);
        st.last       = last_reg;
        st.found      = found_reg;
        st.parse_done = (step_reg == SW'(swfp_pkg::PARSE_STEPS - 1));
        st.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        win_next       = win_reg;
        wt_next        = wt_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        shifted_next   = shifted_reg;
        last_next      = last_reg;
        step_next      = step_reg;
        mant_next      = mant_reg;
        digits_next    = digits_reg;
        after_next     = after_reg;
        point_next     = point_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        status_next    = status_reg;
        mantissa_next  = mantissa_reg;
        exponent_next  = exponent_reg;

        if (cmd.load)
        begin
            last_next    = end_of_read;
            shifted_next = (cnt_reg < LIMIT_C);
            if (cnt_reg < LIMIT_C)
            begin
                for (int i = 0; i < FRAME_LEN - 1; i++)
                    win_next[i] = win_reg[i + 1];
                win_next[FRAME_LEN - 1] = rx_byte;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end

        if (cmd.start_parse)
        begin
            found_next  = 1'b1;
            step_next   = '0;
            mant_next   = '0;
            digits_next = '0;
            after_next  = '0;
            point_next  = 1'b0;
            for (int i = 0; i < swfp_pkg::PARSE_STEPS; i++)
                wt_next[i] = win_reg[swfp_pkg::OFS_WT_FIRST + i];
        end

        if (cmd.step_parse)
        begin
            for (int i = 0; i < swfp_pkg::PARSE_STEPS - 1; i++)
                wt_next[i] = wt_reg[i + 1];
            step_next = step_reg + SW'(1);
            if (is_digit)
            begin
                // mant * 10 + digit, as two shifted adds
                mant_next   = (mant_reg << 3) + (mant_reg << 1) + MW'(digit_val);
                digits_next = digits_reg + CW'(1);
                after_next  = after_reg + CW'(1);
            end
            else if (cur_byte == swfp_pkg::CH_POINT)
            begin
                point_next = 1'b1;
                after_next = '0;
            end
        end

        if (cmd.emit_ok)
        begin
            out_valid_next = 1'b1;
            status_next    = swfp_pkg::STATUS_OK;
            mantissa_next  = mant_reg;
            exponent_next  = exp_calc;
        end
        else if (cmd.emit_nf)
        begin
            out_valid_next = 1'b1;
            status_next    = swfp_pkg::STATUS_NO_FRAME;
            mantissa_next  = '0;
            exponent_next  = '0;
        end

        if (cmd.end_read)
        begin
            cnt_next   = '0;
            found_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            shifted_reg   <= 1'b0;
            last_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            shifted_reg   <= shifted_next;
            last_reg      <= last_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg      <= win_next;
        wt_reg       <= wt_next;
        mant_reg     <= mant_next;
        digits_reg   <= digits_next;
        after_reg    <= after_next;
        point_reg    <= point_next;
        status_reg   <= status_next;
        mantissa_reg <= mantissa_next;
        exponent_reg <= exponent_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign mantissa  = mantissa_reg;
    assign exponent  = signed'(exponent_reg);

    // A frame can only be marked once the window has been filled in this read.
    a_found_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (cnt_reg >= FRAME_C))
        else $error("frame flag set before window filled");

    // Ending a read leaves a clean count and flag.
    a_end_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.end_read |=> (cnt_reg == '0) && !found_reg)
        else $error("read end did not clear per-read state");

    // A result is only loaded when the output register can take it.
    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_ok || cmd.emit_nf) |-> st.out_free)
        else $error("result loaded over a pending result");

    // The byte count never passes the read limit.
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LIMIT_C)
        else $error("byte count above read limit");

endmodule

`default_nettype wire

// ===== rtl/swfp_ctrl.sv =====
// Controller state machine: sequences window update, frame check, parse and result.
// Depends on swfp_pkg; commands swfp_datapath.
`default_nettype none

module swfp_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire swfp_pkg::stat_t st,
    output swfp_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PARSE,
        ST_EMIT_OK,
        ST_EMIT_NF
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (st.hit)
                begin
                    cmd.start_parse = 1'b1;
                    state_next      = ST_PARSE;
                end
                else if (st.last && !st.found)
                    state_next = ST_EMIT_NF;
                else
                begin
                    cmd.end_read = st.last;
                    state_next   = ST_IDLE;
                end
            end
            ST_PARSE:
            begin
                cmd.step_parse = 1'b1;
                if (st.parse_done)
                    state_next = ST_EMIT_OK;
            end
            ST_EMIT_OK:
            begin
                if (st.out_free)
                begin
                    cmd.emit_ok  = 1'b1;
                    cmd.end_read = st.last;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT_NF:
            begin
                if (st.out_free)
                begin
                    cmd.emit_nf  = 1'b1;
                    cmd.end_read = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== bench/scale_weight_frame_parser_top_tb.sv =====
// Self-checking bench for scale_weight_frame_parser_top: drives serial reads byte by byte
// and checks each frame / no-frame result against a predictor of the byte window.
// Depends on swfp_pkg and the RTL of the parser.
module scale_weight_frame_parser_top_tb;

    import swfp_pkg::*;

    localparam int FRAME_LEN    = FRAME_LEN_DEF;
    localparam int READ_CAP     = 2 * FRAME_LEN;
    localparam int ITEM_TARGET  = 1550;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // One weight report as it leaves the block
    typedef struct packed {
        logic                    status;
        logic [MANT_W-1:0]       mantissa;
        logic signed [EXP_W-1:0] exponent;
    } weight_report_t;

    // Predictor: mirrors the byte window and per-read bookkeeping, keeps the
    // reports still owed by the block and compares them in order.
    class weight_ledger;
        logic [7:0]     window [FRAME_LEN];
        int unsigned    read_len;
        bit             reported;
        weight_report_t owed [$];
        int unsigned    errors;

        function new();
            foreach (window[k])
                window[k] = 8'h00;
            read_len = 0;
            reported = 0;
            errors   = 0;
        endfunction

        function automatic bit holds_frame();
            return window[OFS_HEAD] == CH_W && window[OFS_UNIT_K] == CH_K &&
                   window[OFS_UNIT_G] == CH_G;
        endfunction

        // Digits join into the mantissa; the last point, or the digit count if there is none, sets the exponent.
        function automatic weight_report_t decode_weight();
            weight_report_t r;
            int             acc;
            int             digits;
            int             tail;
            bit             point;
            logic [7:0]     b;
            acc    = 0;
            digits = 0;
            tail   = 0;
            point  = 0;
            for (int k = OFS_WT_FIRST; k < OFS_WT_FIRST + PARSE_STEPS; k++)
            begin
                b = window[k];
                if (b >= CH_0 && b <= CH_9)
                begin
                    acc = acc * 10 + int'(b - CH_0);
                    digits++;
                    tail++;
                end
                else if (b == CH_POINT)
                begin
                    point = 1;
                    tail  = 0;
                end
            end
            r.status   = STATUS_OK;
            r.mantissa = MANT_W'(acc);
            r.exponent = EXP_W'(point ? -tail : 7 - digits);
            return r;
        endfunction

        function automatic void note_byte(logic [7:0] value, logic last);
            weight_report_t nf;
            if (read_len < READ_CAP)
            begin
                for (int k = 0; k < FRAME_LEN - 1; k++)
                    window[k] = window[k + 1];
                window[FRAME_LEN - 1] = value;
                read_len++;
                if (!reported && read_len >= FRAME_LEN && holds_frame())
                begin
                    reported = 1;
                    owed.push_back(decode_weight());
                end
            end
            if (last)
            begin
                if (!reported)
                begin
                    nf.status   = STATUS_NO_FRAME;
                    nf.mantissa = '0;
                    nf.exponent = '0;
                    owed.push_back(nf);
                end
                read_len = 0;
                reported = 0;
            end
        endfunction

        function automatic void check_result(logic st, logic [MANT_W-1:0] mant,
                                             logic signed [EXP_W-1:0] expo);
            weight_report_t want;
            if (owed.size() == 0)
            begin
                $error("unexpected result: status %0d mantissa %0d exponent %0d",
                       st, mant, expo);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (st !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, st);
                errors++;
            end
            if (mant !== want.mantissa)
            begin
                $error("mantissa: expected %0d, got %0d", want.mantissa, mant);
                errors++;
            end
            if (expo !== want.exponent)
            begin
                $error("exponent: expected %0d, got %0d", want.exponent, expo);
                errors++;
            end
        endfunction

        function automatic int outstanding();
            return owed.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [7:0]              rx_byte;
    logic                    end_of_read;
    logic                    out_valid;
    logic                    out_ready;
    logic                    status;
    logic [MANT_W-1:0]       mantissa;
    logic signed [EXP_W-1:0] exponent;

    weight_ledger ledger = new();

    logic [7:0] read_bytes [$];     // bytes of the read being sent
    int         items_sent;
    int         tx_burst_left;      // items still to send back to back
    int         hold_request;       // sender asks the receiver for a long hold-off
    int         hold_left;
    int         open_left;
    int         shut_left;

    scale_weight_frame_parser_top #(
        .FRAME_LEN(FRAME_LEN)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .end_of_read(end_of_read),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .mantissa   (mantissa),
        .exponent   (exponent)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Hard stop in case the block hangs; far beyond the slowest legal run.
    initial
    begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Idle cycles before the next item: mostly none or a few, now and then a
    // long pause, and occasional back-to-back bursts with no idling at all.
    function automatic int pick_gap();
        int roll;
        if (tx_burst_left > 0)
        begin
            tx_burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            tx_burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 40)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 80);
    endfunction

    // Filler bytes, biased toward the characters the parser looks for.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 9))
            0:       return CH_W;
            1:       return CH_K;
            2:       return CH_G;
            3:       return CH_POINT;
            4, 5:    return 8'(CH_0 + $urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] weight_byte(int digit_pct);
        int roll;
        if ($urandom_range(0, 99) < digit_pct)
            return 8'(CH_0 + $urandom_range(0, 9));
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return CH_POINT;
        if (roll < 7)
            return CH_SPACE;
        return 8'($urandom_range(0, 255));
    endfunction

    // 14-byte frame: head, sign slot, weight field, unit, two trailing bytes.
    // Some frames get one marker spoiled so they must not match.
    function automatic void push_frame();
        bit         spoiled;
        int         which;
        int         pct;
        logic [7:0] head;
        logic [7:0] unit_k;
        logic [7:0] unit_g;
        spoiled = ($urandom_range(0, 99) < 12);
        which   = $urandom_range(0, 2);
        pct     = $urandom_range(0, 100);
        head    = CH_W;
        unit_k  = CH_K;
        unit_g  = CH_G;
        if (spoiled)
        begin
            case (which)
                0:       head   = CH_W + 8'($urandom_range(1, 255));
                1:       unit_k = CH_K + 8'($urandom_range(1, 255));
                default: unit_g = CH_G + 8'($urandom_range(1, 255));
            endcase
        end
        read_bytes.push_back(head);
        read_bytes.push_back(8'($urandom_range(0, 255)));
        repeat (PARSE_STEPS)
            read_bytes.push_back(weight_byte(pct));
        read_bytes.push_back(unit_k);
        read_bytes.push_back(unit_g);
        read_bytes.push_back(8'($urandom_range(0, 255)));
        read_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Mostly well-formed reads (some leading junk, a frame, some trailing
    // bytes, sometimes a second frame or a frame pushed past the read cap),
    // the rest pure noise of random length.
    function automatic void build_random_read();
        int n;
        read_bytes.delete();
        if ($urandom_range(0, 99) < 75)
        begin
            n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 20);
            repeat (n)
                read_bytes.push_back(noise_byte());
            push_frame();
            if ($urandom_range(0, 4) == 0)
                push_frame();
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 2);
            repeat (n)
                read_bytes.push_back(noise_byte());
        end
        else
        begin
            n = $urandom_range(1, 40);
            repeat (n)
                read_bytes.push_back(noise_byte());
        end
    endfunction

    // Called at the edge where the previous item went in (or right after
    // reset), so in_valid is either held high or lowered here, never both.
    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        rx_byte     <= value;
        end_of_read <= last;
        do
            @(posedge clk);
        while (!in_ready);
        ledger.note_byte(value, last);
        items_sent++;
    endtask

    task automatic send_read();
        for (int i = 0; i < read_bytes.size(); i++)
            send_byte(read_bytes[i], i == read_bytes.size() - 1);
    endtask

    // Sender stops offering until the block has handed back every report.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (ledger.outstanding() != 0);
    endtask

    // Result side: check every accepted result, then pick out_ready for the
    // next cycle. A requested hold-off keeps it low long enough for the block
    // to fill and stall its input while the sender keeps offering bytes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                ledger.check_result(status, mantissa, exponent);
            if (hold_request != 0)
            begin
                hold_request = 0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (open_left > 0)
            begin
                open_left--;
                out_ready <= 1'b1;
            end
            else if (shut_left > 0)
            begin
                shut_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4:
                    begin
                        open_left = $urandom_range(0, 40);
                        out_ready <= 1'b1;
                    end
                    5, 6, 7, 8:
                    begin
                        shut_left = $urandom_range(0, 2);
                        out_ready <= 1'b0;
                    end
                    default:
                    begin
                        shut_left = $urandom_range(10, 60);
                        out_ready <= 1'b0;
                    end
                endcase
            end
        end
    end

    initial
    begin
        int reads;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = 8'h00;
        end_of_read   = 1'b0;
        out_ready     = 1'b0;
        items_sent    = 0;
        tx_burst_left = 0;
        hold_request  = 0;
        hold_left     = 0;
        open_left     = 0;
        shut_left     = 0;
        reads         = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Largest mantissa, no point; the frame completes on the byte that
        // also ends the read, so only the frame result may come out.
        read_bytes.delete();
        read_bytes.push_back(CH_W);
        read_bytes.push_back(8'h00);
        repeat (PARSE_STEPS)
            read_bytes.push_back(CH_9);
        read_bytes.push_back(CH_K);
        read_bytes.push_back(CH_G);
        read_bytes.push_back(8'h00);
        read_bytes.push_back(8'hFF);
        send_read();

        // Short reads at the byte extremes: each ends without a frame.
        read_bytes = '{8'h00, 8'hFF};
        send_read();
        read_bytes = '{8'hFF, 8'h00};
        send_read();

        while (items_sent < ITEM_TARGET)
        begin
            build_random_read();
            send_read();
            reads++;
            if (reads == 30 || reads == 170)
                hold_request = 1;
            if (reads % 60 == 0)
                drain_pipeline();
        end

        in_valid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        // Latency tail: a stray extra result would still show up here.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
